@@ rtl/core/transactional_key_value_table_core_macros.svh @@
// ----------------------------------------------------------------------------
// Transactional key-value table assertion macros
// Shared property templates for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TRANSACTIONAL_KEY_VALUE_TABLE_CORE_MACROS_SVH
`define TRANSACTIONAL_KEY_VALUE_TABLE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKVT_ASSERT_SAME(NAME, CLK, RSTN, ANTE, CONS) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("tkvt check failed");

// The consequent must hold in the cycle after the antecedent.
`define TKVT_ASSERT_NEXT(NAME, CLK, RSTN, ANTE, CONS) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("tkvt check failed");

`endif

@@ rtl/core/tkvt_pkg.sv @@
// ----------------------------------------------------------------------------
// Transactional key-value table package
// Operation and status codes, controller states and the structs that join
// the controller, the datapath and the result register.
// ----------------------------------------------------------------------------
package tkvt_pkg;

    localparam int OP_W      = 3;
    localparam int ST_W      = 3;
    localparam int IN_KEY_W  = 32;
    localparam int VAL_W     = 32;
    localparam int IN_DATA_W = 64;
    localparam int IN_USER_W = 3;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_GET      = 3'd0,
        OP_PUT      = 3'd1,
        OP_BEGIN    = 3'd2,
        OP_COMMIT   = 3'd3,
        OP_ROLLBACK = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_NO_TXN     = 3'd2,
        ST_TXN_ACTIVE = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET_SCAN,
        S_PUT_SCAN,
        S_CM_NEXT,
        S_CM_LOAD,
        S_CM_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load_in;
        logic scan_start;
        logic scan_stage;
        logic fetch;
        logic load_staged;
        logic put_write;
        logic commit_write;
        logic stage_clear;
        logic cidx_clr;
        logic cidx_inc;
        logic full_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic             scan_busy;
        logic             hit;
        logic             stage_full;
        logic             stage_more;
        logic             commit_full;
        logic [VAL_W-1:0] hit_value;
    } t_dp_sts;

    typedef struct packed {
        t_status          status;
        logic             found;
        logic [VAL_W-1:0] value;
    } t_result;

endpackage

@@ rtl/core/transactional_key_value_table_core.sv @@
// ----------------------------------------------------------------------------
// Transactional key-value table core
// Each operation looks a key up in the committed table or works on the
// transaction's staging table and returns one status result. Both tables
// are single-port memories searched one entry per cycle, so an item's time
// is set by the fill of the table it walks: a get walks the committed
// table, a put the staging table, a commit the committed table once per
// staged pair, and begin, rollback and misuse no table. The next item is
// taken once the result has moved to the output register. Tables fill
// from slot zero up; the committed table never shrinks and the staging
// table is emptied only by clearing its count, so fill counters stand in
// for valid bits and no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "transactional_key_value_table_core_macros.svh"

module transactional_key_value_table_core #(
    parameter int MAIN_ENTRIES  = 64,
    parameter int STAGE_ENTRIES = 16,
    parameter int KEY_BITS      = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // key [31:0], value [63:32]
    input  logic [tkvt_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // operation [2:0]
    input  logic [tkvt_pkg::IN_USER_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // read_value [31:0]
    output logic [tkvt_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // status [2:0], found [3]
    output logic [tkvt_pkg::OUT_USER_W-1:0]      m_axis_tuser
);
    import tkvt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_result w_res_in;
    t_result w_res_out;
    logic    w_res_push;
    logic    w_res_ready;

    tkvt_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser[OP_W-1:0]),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .i_res_ready (w_res_ready),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    tkvt_datapath #(
        .MAIN_ENTRIES  (MAIN_ENTRIES),
        .STAGE_ENTRIES (STAGE_ENTRIES),
        .KEY_BITS      (KEY_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_key   (s_axis_tdata[IN_KEY_W-1:0]),
        .i_value (s_axis_tdata[IN_KEY_W+VAL_W-1:IN_KEY_W]),
        .o_sts   (w_sts)
    );

    tkvt_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res_in),
        .o_ready (w_res_ready),
        .o_valid (m_axis_tvalid),
        .i_take  (m_axis_tready),
        .o_res   (w_res_out)
    );

    assign m_axis_tdata = w_res_out.value;
    assign m_axis_tuser = {w_res_out.found, w_res_out.status};

    `TKVT_ASSERT_SAME(a_ready_scan_idle, i_clk, i_rst_n, s_axis_tready, !w_sts.scan_busy)
    `TKVT_ASSERT_SAME(a_push_has_room, i_clk, i_rst_n, w_res_push, w_res_ready)
    `TKVT_ASSERT_NEXT(a_scan_starts, i_clk, i_rst_n, w_cmd.scan_start, w_sts.scan_busy)

endmodule

@@ rtl/core/tkvt_datapath.sv @@
// ----------------------------------------------------------------------------
// Transactional key-value table datapath
// Committed and staging memories, fill counters, the linear key scan engine
// and the write logic for put and commit.
// ----------------------------------------------------------------------------
module tkvt_datapath #(
    parameter int MAIN_ENTRIES  = 64,
    parameter int STAGE_ENTRIES = 16,
    parameter int KEY_BITS      = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tkvt_pkg::t_dp_cmd                    i_cmd,
    input  logic [tkvt_pkg::IN_KEY_W-1:0]        i_key,
    input  logic signed [tkvt_pkg::VAL_W-1:0]    i_value,
    output tkvt_pkg::t_dp_sts                    o_sts
);
    import tkvt_pkg::*;

    localparam int KW  = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
    localparam int MAW = (MAIN_ENTRIES > 1) ? $clog2(MAIN_ENTRIES) : 1;
    localparam int SAW = (STAGE_ENTRIES > 1) ? $clog2(STAGE_ENTRIES) : 1;
    localparam int MCW = $clog2(MAIN_ENTRIES + 1);
    localparam int SCW = $clog2(STAGE_ENTRIES + 1);
    localparam int PW  = (MCW > SCW) ? MCW : SCW;

    logic [KW-1:0]    r_main_keys  [MAIN_ENTRIES];
    logic [VAL_W-1:0] r_main_vals  [MAIN_ENTRIES];
    logic [KW-1:0]    r_stage_keys [STAGE_ENTRIES];
    logic [VAL_W-1:0] r_stage_vals [STAGE_ENTRIES];

    logic [KW-1:0]    r_main_key_rd;
    logic [VAL_W-1:0] r_main_val_rd;
    logic [KW-1:0]    r_stage_key_rd;
    logic [VAL_W-1:0] r_stage_val_rd;

    logic [KW-1:0]    r_key;
    logic [VAL_W-1:0] r_val;
    logic [MCW-1:0]   r_main_cnt;
    logic [SCW-1:0]   r_stage_cnt;
    logic [SCW-1:0]   r_cidx;
    logic             r_scan_busy;
    logic             r_scan_stage;
    logic [PW-1:0]    r_scan_ptr;
    logic             r_rd_vld;
    logic [PW-1:0]    r_rd_ptr;
    logic             r_hit;
    logic [PW-1:0]    r_hit_slot;
    logic [VAL_W-1:0] r_hit_val;
    logic             r_full;

    logic [PW-1:0]  w_limit;
    logic [KW-1:0]  w_cmp_key;
    logic           w_match;
    logic           w_issue;
    logic [MAW-1:0] w_main_rd_addr;
    logic [SAW-1:0] w_stage_rd_addr;
    logic           w_main_full;
    logic           w_stage_full;
    logic           w_mwe;
    logic [MAW-1:0] w_mw_addr;
    logic           w_swe;
    logic [SAW-1:0] w_sw_addr;

    assign w_limit   = r_scan_stage ? PW'(r_stage_cnt) : PW'(r_main_cnt);
    assign w_cmp_key = r_scan_stage ? r_stage_key_rd : r_main_key_rd;
    assign w_match   = r_scan_busy && r_rd_vld && (w_cmp_key == r_key);
    assign w_issue   = r_scan_busy && !w_match && (r_scan_ptr < w_limit);

    assign w_main_rd_addr  = r_scan_ptr[MAW-1:0];
    assign w_stage_rd_addr = i_cmd.fetch ? r_cidx[SAW-1:0] : r_scan_ptr[SAW-1:0];

    assign w_main_full  = (r_main_cnt == MCW'(MAIN_ENTRIES));
    assign w_stage_full = (r_stage_cnt == SCW'(STAGE_ENTRIES));

    assign w_mwe     = i_cmd.commit_write && (r_hit || !w_main_full);
    assign w_mw_addr = r_hit ? r_hit_slot[MAW-1:0] : r_main_cnt[MAW-1:0];
    assign w_swe     = i_cmd.put_write && (r_hit || !w_stage_full);
    assign w_sw_addr = r_hit ? r_hit_slot[SAW-1:0] : r_stage_cnt[SAW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            r_main_keys[w_mw_addr] <= r_key;
            r_main_vals[w_mw_addr] <= r_val;
        end
        r_main_key_rd <= r_main_keys[w_main_rd_addr];
        r_main_val_rd <= r_main_vals[w_main_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            r_stage_keys[w_sw_addr] <= r_key;
            r_stage_vals[w_sw_addr] <= r_val;
        end
        r_stage_key_rd <= r_stage_keys[w_stage_rd_addr];
        r_stage_val_rd <= r_stage_vals[w_stage_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_key <= i_key[KW-1:0];
            r_val <= i_value;
        end else if (i_cmd.load_staged) begin
            r_key <= r_stage_key_rd;
            r_val <= r_stage_val_rd;
        end
        if (w_match) begin
            r_hit_slot <= r_rd_ptr;
            r_hit_val  <= r_main_val_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_cnt   <= '0;
            r_stage_cnt  <= '0;
            r_cidx       <= '0;
            r_scan_busy  <= 1'b0;
            r_scan_stage <= 1'b0;
            r_scan_ptr   <= '0;
            r_rd_vld     <= 1'b0;
            r_rd_ptr     <= '0;
            r_hit        <= 1'b0;
            r_full       <= 1'b0;
        end else begin
            if (i_cmd.stage_clear) begin
                r_stage_cnt <= '0;
            end else if (w_swe && !r_hit) begin
                r_stage_cnt <= r_stage_cnt + SCW'(1);
            end
            if (w_mwe && !r_hit) begin
                r_main_cnt <= r_main_cnt + MCW'(1);
            end
            if (i_cmd.cidx_clr) begin
                r_cidx <= '0;
            end else if (i_cmd.cidx_inc) begin
                r_cidx <= r_cidx + SCW'(1);
            end
            if (i_cmd.full_clr) begin
                r_full <= 1'b0;
            end else if (i_cmd.commit_write && !r_hit && w_main_full) begin
                r_full <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_scan_busy  <= 1'b1;
                r_scan_stage <= i_cmd.scan_stage;
                r_scan_ptr   <= '0;
                r_rd_vld     <= 1'b0;
                r_hit        <= 1'b0;
            end else if (r_scan_busy) begin
                if (w_match) begin
                    r_scan_busy <= 1'b0;
                    r_hit       <= 1'b1;
                end else if (w_issue) begin
                    r_rd_vld   <= 1'b1;
                    r_rd_ptr   <= r_scan_ptr;
                    r_scan_ptr <= r_scan_ptr + PW'(1);
                end else begin
                    r_scan_busy <= 1'b0;
                    r_hit       <= 1'b0;
                end
            end
        end
    end

    assign o_sts.scan_busy   = r_scan_busy;
    assign o_sts.hit         = r_hit;
    assign o_sts.stage_full  = w_stage_full;
    assign o_sts.stage_more  = (r_cidx < r_stage_cnt);
    assign o_sts.commit_full = r_full;
    assign o_sts.hit_value   = r_hit_val;

endmodule

@@ rtl/core/tkvt_controller.sv @@
// ----------------------------------------------------------------------------
// Transactional key-value table controller
// Decodes each operation, tracks the open transaction and sequences the
// datapath through lookups, staging writes and the commit walk.
// ----------------------------------------------------------------------------
module tkvt_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tkvt_pkg::OP_W-1:0]     i_op,
    input  tkvt_pkg::t_dp_sts             i_sts,
    output tkvt_pkg::t_dp_cmd             o_cmd,
    input  logic                          i_res_ready,
    output logic                          o_res_push,
    output tkvt_pkg::t_result             o_res
);
    import tkvt_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_txn;
    logic    n_txn;
    t_result r_res;
    t_result n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_txn   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_txn   <= n_txn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_txn      = r_txn;
        n_res      = r_res;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        o_res_push = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_res.status  = ST_OK;
                    n_res.found   = 1'b0;
                    n_res.value   = '0;
                    n_state       = S_RESP;
                    unique case (t_op'(i_op))
                        OP_GET: begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_GET_SCAN;
                        end
                        OP_PUT: begin
                            if (!r_txn) begin
                                n_res.status = ST_NO_TXN;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                                o_cmd.scan_stage = 1'b1;
                                n_state          = S_PUT_SCAN;
                            end
                        end
                        OP_BEGIN: begin
                            if (r_txn) begin
                                n_res.status = ST_TXN_ACTIVE;
                            end else begin
                                n_txn             = 1'b1;
                                o_cmd.stage_clear = 1'b1;
                            end
                        end
                        OP_COMMIT: begin
                            if (!r_txn) begin
                                n_res.status = ST_NO_TXN;
                            end else begin
                                o_cmd.cidx_clr = 1'b1;
                                o_cmd.full_clr = 1'b1;
                                n_state        = S_CM_NEXT;
                            end
                        end
                        OP_ROLLBACK: begin
                            if (!r_txn) begin
                                n_res.status = ST_NO_TXN;
                            end else begin
                                n_txn             = 1'b0;
                                o_cmd.stage_clear = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_GET_SCAN: begin
                if (!i_sts.scan_busy) begin
                    if (i_sts.hit) begin
                        n_res.status = ST_OK;
                        n_res.found  = 1'b1;
                        n_res.value  = i_sts.hit_value;
                    end else begin
                        n_res.status = ST_NOT_FOUND;
                    end
                    n_state = S_RESP;
                end
            end
            S_PUT_SCAN: begin
                if (!i_sts.scan_busy) begin
                    o_cmd.put_write = 1'b1;
                    if (!i_sts.hit && i_sts.stage_full) begin
                        n_res.status = ST_FULL;
                    end
                    n_state = S_RESP;
                end
            end
            S_CM_NEXT: begin
                if (i_sts.stage_more) begin
                    o_cmd.fetch = 1'b1;
                    n_state     = S_CM_LOAD;
                end else begin
                    o_cmd.stage_clear = 1'b1;
                    n_txn             = 1'b0;
                    if (i_sts.commit_full) begin
                        n_res.status = ST_FULL;
                    end
                    n_state = S_RESP;
                end
            end
            S_CM_LOAD: begin
                o_cmd.load_staged = 1'b1;
                o_cmd.scan_start  = 1'b1;
                n_state           = S_CM_SCAN;
            end
            S_CM_SCAN: begin
                if (!i_sts.scan_busy) begin
                    o_cmd.commit_write = 1'b1;
                    o_cmd.cidx_inc     = 1'b1;
                    n_state            = S_CM_NEXT;
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

@@ rtl/core/tkvt_out_reg.sv @@
// ----------------------------------------------------------------------------
// Transactional key-value table result register
// Holds one finished result for the output stream so the controller can
// take the next operation while the result waits for its transfer.
// ----------------------------------------------------------------------------
module tkvt_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tkvt_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_take,
    output tkvt_pkg::t_result o_res
);
    import tkvt_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transactional key-value table core testbench
// Sends get, put, begin, commit and rollback operations, mostly as
// well-formed transactions on a small pool of keys, plus misuse and spare
// codes. A model of the committed and staging tables predicts every result.
// Results are checked in order, with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module tb;
    import tkvt_pkg::*;

    localparam int MAIN_N         = 64;
    localparam int STAGE_N        = 16;
    localparam int POOL_N         = 80;
    localparam int TARGET_OPS     = 1700;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 50;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [IN_KEY_W-1:0] key;
        logic [VAL_W-1:0]    value;
    } t_kv_request;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // Fields from bit 0 up: key, value.
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // Fields from bit 0 up: operation.
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // Fields from bit 0 up: read_value.
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // Fields from bit 0 up: status, found.
    logic [OUT_USER_W-1:0] m_axis_tuser;

    t_kv_request     op_backlog[$];
    t_result         pending_outcomes[$];
    logic [IN_KEY_W-1:0] key_pool [POOL_N];

    logic [IN_KEY_W-1:0] main_key [MAIN_N];
    logic [VAL_W-1:0]    main_val [MAIN_N];
    bit                  main_vld [MAIN_N];
    logic [IN_KEY_W-1:0] stage_key [STAGE_N];
    logic [VAL_W-1:0]    stage_val [STAGE_N];
    bit                  stage_vld [STAGE_N];
    bit                  txn_open;

    int planned_ops;
    int accepted_ops;
    int outcomes_checked;
    int mismatch_count;
    int get_hits;
    int refused_puts;
    int full_commits;
    int misuse_count;
    int ignored_count;
    int quiet_cycles;
    int send_gap;
    int recv_stall;
    bit send_calm;
    bit recv_calm;

    transactional_key_value_table_core #(
        .MAIN_ENTRIES  (MAIN_N),
        .STAGE_ENTRIES (STAGE_N),
        .KEY_BITS      (IN_KEY_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic int main_slot(input logic [IN_KEY_W-1:0] key);
        for (int i = 0; i < MAIN_N; i++) begin
            if (main_vld[i] && main_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_result kv_outcome(input logic [OP_W-1:0] op,
                                           input logic [IN_KEY_W-1:0] key,
                                           input logic [VAL_W-1:0] val);
        t_result r;
        int      slot;
        int      i;
        int      j;
        r.status = ST_OK;
        r.found  = 1'b0;
        r.value  = '0;
        slot     = -1;
        case (op)
            OP_GET: begin
                slot = main_slot(key);
                if (slot >= 0) begin
                    r.found = 1'b1;
                    r.value = main_val[slot];
                    get_hits++;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_PUT: begin
                if (!txn_open) begin
                    r.status = ST_NO_TXN;
                end else begin
                    for (i = 0; i < STAGE_N && slot < 0; i++) begin
                        if (stage_vld[i] && stage_key[i] == key) slot = i;
                    end
                    for (i = 0; i < STAGE_N && slot < 0; i++) begin
                        if (!stage_vld[i]) slot = i;
                    end
                    if (slot < 0) begin
                        r.status = ST_FULL;
                        refused_puts++;
                    end else begin
                        stage_key[slot] = key;
                        stage_val[slot] = val;
                        stage_vld[slot] = 1'b1;
                    end
                end
            end
            OP_BEGIN: begin
                if (txn_open) begin
                    r.status = ST_TXN_ACTIVE;
                end else begin
                    txn_open  = 1'b1;
                    stage_vld = '{default: 1'b0};
                end
            end
            OP_COMMIT: begin
                if (!txn_open) begin
                    r.status = ST_NO_TXN;
                end else begin
                    for (i = 0; i < STAGE_N; i++) begin
                        if (stage_vld[i]) begin
                            slot = main_slot(stage_key[i]);
                            for (j = 0; j < MAIN_N && slot < 0; j++) begin
                                if (!main_vld[j]) slot = j;
                            end
                            if (slot < 0) begin
                                r.status = ST_FULL;
                            end else begin
                                main_key[slot] = stage_key[i];
                                main_val[slot] = stage_val[i];
                                main_vld[slot] = 1'b1;
                            end
                        end
                    end
                    if (r.status == ST_FULL) full_commits++;
                    stage_vld = '{default: 1'b0};
                    txn_open  = 1'b0;
                end
            end
            OP_ROLLBACK: begin
                if (!txn_open) begin
                    r.status = ST_NO_TXN;
                end else begin
                    stage_vld = '{default: 1'b0};
                    txn_open  = 1'b0;
                end
            end
            default: begin
                ignored_count++;
            end
        endcase
        if (r.status == ST_NO_TXN || r.status == ST_TXN_ACTIVE) misuse_count++;
        return r;
    endfunction

    function automatic int draw_idle(inout bit calm, input int chance, input int toggle_odds);
        if ($urandom_range(0, toggle_odds - 1) == 0) calm = !calm;
        if (calm || $urandom_range(0, 99) >= chance) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [IN_KEY_W-1:0] pick_key();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return key_pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    task automatic push_op(input logic [OP_W-1:0] op, input logic [IN_KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val);
        t_kv_request req;
        req.op    = op;
        req.key   = key;
        req.value = val;
        op_backlog.push_back(req);
        if (op <= OP_ROLLBACK) planned_ops++;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch in %s at result %0d: expected %h, got %h",
                     what, outcomes_checked, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_outcomes.push_back(kv_outcome(s_axis_tuser,
                    s_axis_tdata[IN_KEY_W-1:0], s_axis_tdata[IN_KEY_W +: VAL_W]));
                void'(op_backlog.pop_front());
                accepted_ops++;
                send_gap = draw_idle(send_calm, 20, 120);
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                s_axis_tvalid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (op_backlog.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= op_backlog[0].op;
                s_axis_tdata  <= {op_backlog[0].value, op_backlog[0].key};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                outcomes_checked++;
                if (pending_outcomes.size() == 0) begin
                    flag_mismatch("unexpected transfer", '0, m_axis_tdata);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_axis_tuser[ST_W-1:0] != want.status) begin
                        flag_mismatch("status", 32'(want.status),
                                      32'(m_axis_tuser[ST_W-1:0]));
                    end
                    if (m_axis_tuser[ST_W] != want.found) begin
                        flag_mismatch("found", 32'(want.found), 32'(m_axis_tuser[ST_W]));
                    end
                    if (m_axis_tdata != want.value) begin
                        flag_mismatch("read_value", want.value, m_axis_tdata);
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_stall = draw_idle(recv_calm, 6, 800);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending_outcomes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int          n;
        int          base;
        int          filled;
        bit          flood;
        logic [IN_KEY_W-1:0] k;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int p = 2; p < POOL_N; p++) key_pool[p] = $urandom;

        push_op(OP_GET, 32'h0000_0000, $urandom);
        push_op(OP_PUT, 32'h0000_0000, $urandom);
        push_op(OP_COMMIT, $urandom, $urandom);
        push_op(OP_ROLLBACK, $urandom, $urandom);
        push_op(OP_BEGIN, $urandom, $urandom);
        push_op(OP_BEGIN, $urandom, $urandom);
        push_op(OP_PUT, 32'h0000_0000, 32'h8000_0000);
        push_op(OP_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        push_op(OP_GET, 32'h0000_0000, $urandom);
        push_op(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        push_op(OP_COMMIT, $urandom, $urandom);
        push_op(OP_GET, 32'h0000_0000, $urandom);
        push_op(OP_GET, 32'hFFFF_FFFF, $urandom);
        push_op(OP_BEGIN, $urandom, $urandom);
        push_op(OP_PUT, 32'h0000_0000, 32'h0000_0001);
        push_op(OP_GET, 32'h0000_0000, $urandom);
        push_op(OP_ROLLBACK, $urandom, $urandom);
        push_op(OP_GET, 32'h0000_0000, $urandom);
        push_op(OP_RSVD_A, $urandom, $urandom);
        push_op(OP_RSVD_B, $urandom, $urandom);
        push_op(OP_RSVD_C, $urandom, $urandom);
        push_op(OP_BEGIN, $urandom, $urandom);
        push_op(OP_COMMIT, $urandom, $urandom);

        // Floods stage distinct pool keys so that staging and later the
        // committed table run full.
        while (planned_ops < TARGET_OPS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                    push_op(OP_BEGIN, $urandom, $urandom);
                    flood = ($urandom_range(0, 9) == 0);
                    n     = flood ? $urandom_range(STAGE_N + 1, STAGE_N + 4)
                                  : $urandom_range(0, 6);
                    base  = $urandom_range(0, POOL_N - 1);
                    for (int i = 0; i < n; i++) begin
                        k = flood ? key_pool[(base + i) % POOL_N] : pick_key();
                        push_op(OP_PUT, k, $urandom);
                        case ($urandom_range(0, 9))
                            0: push_op(OP_GET, pick_key(), $urandom);
                            1: push_op(OP_PUT, k, $urandom);
                            2: push_op(OP_GET, k, $urandom);
                            3: push_op(OP_BEGIN, $urandom, $urandom);
                            default: ;
                        endcase
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        push_op(OP_COMMIT, $urandom, $urandom);
                    end else begin
                        push_op(OP_ROLLBACK, $urandom, $urandom);
                    end
                end
                12, 13, 14, 15, 16: begin
                    repeat ($urandom_range(1, 6)) push_op(OP_GET, pick_key(), $urandom);
                end
                default: begin
                    repeat ($urandom_range(1, 3)) begin
                        push_op(OP_W'($urandom_range(0, 7)), $urandom, $urandom);
                    end
                end
            endcase
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        while (pending_outcomes.size() != 0) begin
            flag_mismatch("missing transfer", pending_outcomes[0].value, '0);
            void'(pending_outcomes.pop_front());
        end

        filled = 0;
        for (int i = 0; i < MAIN_N; i++) filled += main_vld[i];
        $display("Sent %0d operations: %0d get hits, %0d puts refused by full staging,",
                 accepted_ops, get_hits, refused_puts);
        $display("%0d full commits, %0d misuse, %0d spare codes, %0d/%0d slots, %0d checked.",
                 full_commits, misuse_count, ignored_count, filled, MAIN_N,
                 outcomes_checked);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
